// File: sv/pgphp_pkg.sv
`timescale 1ns / 1ps

package pgphp_pkg;

    // Width of a decoded body length; longer lengths saturate.
    localparam int LENGTH_BITS = 32;
    localparam logic [31:0] LENGTH_MAX = 32'((33'd1 << LENGTH_BITS) - 33'd1);

    // Tag byte fields.
    localparam logic [7:0] TAG_VALID_BIT  = 8'h80;
    localparam logic [7:0] TAG_NEW_BIT    = 8'h40;

    // New-format first length byte boundaries.
    localparam logic [7:0] NEW_TWO_BYTE_MIN = 8'd192;
    localparam logic [7:0] NEW_PARTIAL_MIN  = 8'd224;
    localparam logic [7:0] NEW_FIVE_BYTE    = 8'd255;

    // Old-format length types.
    localparam logic [1:0] OLD_LEN_ONE   = 2'd0;
    localparam logic [1:0] OLD_LEN_TWO   = 2'd1;
    localparam logic [1:0] OLD_LEN_FOUR  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_NEW_FIRST  = 3'd1,
        PH_NEW_SECOND = 3'd2,
        PH_MULTI      = 3'd3,
        PH_BODY       = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RK_HEADER = 2'd0,
        RK_BODY   = 2'd1,
        RK_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_TAG_BIT7      = 2'd1,
        ERR_OLD_INDETERM  = 2'd2
    } error_code_t;

    typedef struct packed {
        result_kind_t kind;
        logic         new_format;
        logic [5:0]   tag;
        logic [31:0]  length;
        logic         partial;
        logic [7:0]   data;
        logic         last;
        error_code_t  err;
    } result_t;

    // Clamp a decoded length to the supported length width.
    function automatic logic [31:0] sat_len(input logic [31:0] v);
        logic [31:0] r;
        r = (v > LENGTH_MAX) ? LENGTH_MAX : v;
        return r;
    endfunction

endpackage

// File: sv/pgp_packet_header_parser_core.sv
`timescale 1ns / 1ps

// OpenPGP packet header parser. The input channel (in_valid, in_stall,
// in_byte) carries the packet stream one byte per transaction. Tag and
// length bytes are consumed silently until the header is complete; then
// one header transaction appears on the output channel, followed by one
// body transaction per body byte, the final one flagged by last_byte.
// A malformed tag byte or an old-format indeterminate length produces a
// single error transaction and the parser returns to waiting for a tag.
// A result is registered at the edge that accepts its byte. Throughput is
// one byte per cycle while in_stall is low, limited only by the single
// state update done per byte. When the receiver raises out_stall the
// held result stays put, and one further result is caught in a skid
// register; only once that register is occupied does in_stall rise, so
// the input side never waits on a cycle-by-cycle basis for the output.
// Reset (rst_n low, asynchronous) empties both output registers and puts
// the parser in its idle phase, where the next byte is taken as a tag.
module pgp_packet_header_parser_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            result_kind,
    output logic                  new_format,
    output logic [5:0]            packet_tag,
    output logic [31:0]           body_length,
    output logic                  partial_body,
    output logic [7:0]            data_byte,
    output logic                  last_byte,
    output logic [1:0]            error_code
);
    import pgphp_pkg::*;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic        is_new_reg, is_new_next;
    logic [5:0]  tag_reg, tag_next;
    logic [31:0] accum_reg, accum_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [4:0]  first_low_reg, first_low_next;
    logic [31:0] body_left_reg, body_left_next;
    logic        partial_reg, partial_next;

    // Output register and skid register.
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic        skid_valid_reg;
    result_t     skid_res_reg;

    logic        accept;
    logic        res_valid;
    result_t     res;
    logic        out_free;

    logic [31:0] hdr_len;
    logic        hdr_fire;
    logic [31:0] hdr_sat;
    logic [31:0] multi_accum;
    logic [2:0]  multi_left;
    logic [31:0] body_dec;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign hdr_sat     = sat_len(hdr_len);
    assign multi_accum = {accum_reg[23:0], in_byte};
    assign multi_left  = len_left_reg - 3'd1;
    assign body_dec    = body_left_reg - 32'd1;

    // Decode one byte: next state and the result it causes, if any.
    always_comb
    begin
        phase_next     = phase_reg;
        is_new_next    = is_new_reg;
        tag_next       = tag_reg;
        accum_next     = accum_reg;
        len_left_next  = len_left_reg;
        first_low_next = first_low_reg;
        body_left_next = body_left_reg;
        partial_next   = partial_reg;
        res_valid      = 1'b0;
        res            = '0;
        hdr_len        = 32'd0;
        hdr_fire       = 1'b0;

        case (phase_reg)
            PH_NEW_FIRST:
            begin
                first_low_next = in_byte[4:0];
                if (in_byte < NEW_TWO_BYTE_MIN)
                begin
                    hdr_len  = {24'd0, in_byte};
                    hdr_fire = 1'b1;
                end
                else if (in_byte < NEW_PARTIAL_MIN)
                begin
                    phase_next = PH_NEW_SECOND;
                end
                else if (in_byte < NEW_FIVE_BYTE)
                begin
                    // Partial chunk of 2^(byte - 224); the low five bits are the exponent.
                    partial_next = 1'b1;
                    hdr_len      = 32'd1 << in_byte[4:0];
                    hdr_fire     = 1'b1;
                end
                else
                begin
                    accum_next    = 32'd0;
                    len_left_next = 3'd4;
                    phase_next    = PH_MULTI;
                end
            end

            PH_NEW_SECOND:
            begin
                hdr_len  = 32'({first_low_reg, in_byte}) + 32'(NEW_TWO_BYTE_MIN);
                hdr_fire = 1'b1;
            end

            PH_MULTI:
            begin
                accum_next    = multi_accum;
                len_left_next = multi_left;
                if (multi_left == 3'd0)
                begin
                    hdr_len  = multi_accum;
                    hdr_fire = 1'b1;
                end
            end

            PH_BODY:
            begin
                body_left_next = body_dec;
                res_valid      = 1'b1;
                res.kind       = RK_BODY;
                res.new_format = is_new_reg;
                res.tag        = tag_reg;
                res.length     = accum_reg;
                res.partial    = partial_reg;
                res.data       = in_byte;
                res.last       = (body_dec == 32'd0);
                res.err        = ERR_NONE;
                if (body_dec == 32'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end

            default:
            begin
                // Idle: the byte is a tag byte.
                phase_next     = PH_IDLE;
                partial_next   = 1'b0;
                accum_next     = 32'd0;
                body_left_next = 32'd0;
                if ((in_byte & TAG_VALID_BIT) == 8'd0)
                begin
                    is_new_next = 1'b0;
                    tag_next    = 6'd0;
                    res_valid   = 1'b1;
                    res.kind    = RK_ERROR;
                    res.err     = ERR_TAG_BIT7;
                end
                else if ((in_byte & TAG_NEW_BIT) != 8'd0)
                begin
                    is_new_next = 1'b1;
                    tag_next    = in_byte[5:0];
                    phase_next  = PH_NEW_FIRST;
                end
                else
                begin
                    is_new_next = 1'b0;
                    tag_next    = {2'b00, in_byte[5:2]};
                    case (in_byte[1:0])
                        OLD_LEN_ONE:
                        begin
                            len_left_next = 3'd1;
                            phase_next    = PH_MULTI;
                        end
                        OLD_LEN_TWO:
                        begin
                            len_left_next = 3'd2;
                            phase_next    = PH_MULTI;
                        end
                        OLD_LEN_FOUR:
                        begin
                            len_left_next = 3'd4;
                            phase_next    = PH_MULTI;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                            res.kind  = RK_ERROR;
                            res.tag   = {2'b00, in_byte[5:2]};
                            res.err   = ERR_OLD_INDETERM;
                        end
                    endcase
                end
            end
        endcase

        // A completed header is reported and opens the body, if any.
        if (hdr_fire)
        begin
            accum_next     = hdr_sat;
            body_left_next = hdr_sat;
            phase_next     = (hdr_sat != 32'd0) ? PH_BODY : PH_IDLE;
            res_valid      = 1'b1;
            res.kind       = RK_HEADER;
            res.new_format = is_new_reg;
            res.tag        = tag_reg;
            res.length     = hdr_sat;
            res.partial    = partial_next;
            res.err        = ERR_NONE;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            is_new_reg    <= 1'b0;
            tag_reg       <= 6'd0;
            accum_reg     <= 32'd0;
            len_left_reg  <= 3'd0;
            first_low_reg <= 5'd0;
            body_left_reg <= 32'd0;
            partial_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            is_new_reg    <= is_new_next;
            tag_reg       <= tag_next;
            accum_reg     <= accum_next;
            len_left_reg  <= len_left_next;
            first_low_reg <= first_low_next;
            body_left_reg <= body_left_next;
            partial_reg   <= partial_next;
        end
    end

    // Output and skid valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept && res_valid;
            end
        end
        else if (accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payloads.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg <= skid_res_reg;
            end
            else if (accept && res_valid)
            begin
                out_res_reg <= res;
            end
        end
        else if (accept && res_valid)
        begin
            skid_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_res_reg.kind;
    assign new_format   = out_res_reg.new_format;
    assign packet_tag   = out_res_reg.tag;
    assign body_length  = out_res_reg.length;
    assign partial_body = out_res_reg.partial;
    assign data_byte    = out_res_reg.data;
    assign last_byte    = out_res_reg.last;
    assign error_code   = out_res_reg.err;

endmodule
